[hdl/als_pkg.sv]
// ----------------------------------------------------------------------------
// Adaptive leaky synapse package
// Field widths, event and register codes, exp table and rounding helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package als_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STIM_W    = 16;
  localparam int unsigned DT_W      = 21;
  localparam int unsigned REW_W     = 14;
  localparam int unsigned SRC_W     = 14;
  localparam int unsigned CPL_W     = 15;
  localparam int unsigned ACT_W     = 14;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_W     = 19;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_W     = 30;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned EXP_STEPS = 20;

  typedef enum logic [FUNC_W-1:0] {
    FN_PULSE  = 2'd0,
    FN_REINF  = 2'd1,
    FN_COUPLE = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PDECAY = 3'd0,
    REG_TDECAY = 3'd1,
    REG_THRESH = 3'd2,
    REG_GAIN   = 3'd3,
    REG_LRATE  = 3'd4,
    REG_WFLOOR = 3'd5,
    REG_WCEIL  = 3'd6,
    REG_HOMEO  = 3'd7
  } cfg_idx_e;

  localparam logic signed [14:0] TARGET_ACT = 15'sd1434;
  localparam logic [15:0]        WGT_RESET  = 16'd4096;

  // round(65536 * exp(-2^(k-16)))
  localparam logic [15:0] EXP_TAB [EXP_STEPS] = '{
    16'd65535, 16'd65534, 16'd65532, 16'd65528, 16'd65520, 16'd65504, 16'd65472,
    16'd65408, 16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
    16'd51039, 16'd39750, 16'd24109, 16'd8869,  16'd1200,  16'd22
  };

  // Scale back by 2^s, rounding to nearest with ties away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned s);
    logic [PROD_W-1:0] mag;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    mag = (mag + (PROD_W'(1) << (s - 1))) >> s;
    return v[PROD_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

[hdl/als_if.sv]
// ----------------------------------------------------------------------------
// Adaptive leaky synapse channels
// Event channel into the synapse and result channel out of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface als_in_if import als_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [STIM_W-1:0] stimulus;
  logic signed [STIM_W-1:0] modulation_value;
  logic [DT_W-1:0]          time_step;
  logic signed [REW_W-1:0]  reward_value;
  logic signed [SRC_W-1:0]  source_level;
  logic signed [CPL_W-1:0]  coupling_strength;

  modport source (output valid, func, stimulus, modulation_value, time_step,
                  reward_value, source_level, coupling_strength, input ready);
  modport sink   (input valid, func, stimulus, modulation_value, time_step,
                  reward_value, source_level, coupling_strength, output ready);
endinterface

interface als_out_if import als_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACT_W-1:0] activation_out;
  logic [CNT_W-1:0]        pulse_count;

  modport source (output valid, activation_out, pulse_count, input ready);
  modport sink   (input valid, activation_out, pulse_count, output ready);
endinterface

`default_nettype wire

[hdl/adaptive_leaky_synapse.sv]
// ----------------------------------------------------------------------------
// Adaptive leaky synapse
// One synapse with leaky potential, tanh activation, eligibility trace,
// reward-driven weight and homeostatic threshold, on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: events enter on in_i (pulse, reinforce, couple); only a pulse makes
// a word on out_o (activation and pulse count). in_i.ready is high only while
// the sequencer is idle, so one event is worked at a time.
// A pulse evaluates three exp terms and then divides out the tanh. Each
// exp walks 20 argument bits, with a multiply and then a round for each
// set bit; the tanh divide is a restoring division that yields 13
// quotient bits.
// All products go through one 30x30 signed multiplier with a registered
// product. A pulse result sits in an output register; if the receiver
// stalls and that register is still full, the next pulse holds in its last
// step until the register drains, and no other event is taken meanwhile.
// Reset clears synapse state, loads register defaults and the weight of 1.0.
// Configuration writes apply the next cycle and are meant for idle times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adaptive_leaky_synapse import als_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  als_in_if.sink               in_i,
  als_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [27:0] {
    S_IDLE = 28'd1 << 0,  S_PD0 = 28'd1 << 1,  S_PD1 = 28'd1 << 2,
    S_TD0  = 28'd1 << 3,  S_TD1 = 28'd1 << 4,  S_EXPM = 28'd1 << 5,
    S_EXPR = 28'd1 << 6,  S_XW  = 28'd1 << 7,  S_MT  = 28'd1 << 8,
    S_DRV  = 28'd1 << 9,  S_PM  = 28'd1 << 10, S_POT = 28'd1 << 11,
    S_Z    = 28'd1 << 12, S_TA  = 28'd1 << 13, S_DV0 = 28'd1 << 14,
    S_DIV  = 28'd1 << 15, S_ACT = 28'd1 << 16, S_TDM = 28'd1 << 17,
    S_TR   = 28'd1 << 18, S_H1  = 28'd1 << 19, S_H2  = 28'd1 << 20,
    S_OUT  = 28'd1 << 21, S_R0  = 28'd1 << 22, S_R1  = 28'd1 << 23,
    S_R2   = 28'd1 << 24, S_R3  = 28'd1 << 25, S_C0  = 28'd1 << 26,
    S_C1   = 28'd1 << 27
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // configuration
  logic [18:0]        pdr_q, tdr_q;
  logic signed [15:0] thr_q;
  logic [16:0]        gain_q;
  logic [12:0]        lr_q;
  logic [15:0]        wfl_q, wcl_q, homeo_q;

  // synapse state
  logic signed [19:0] pot_q, pot_d;
  logic signed [13:0] act_q, act_d, trace_q, trace_d;
  logic [15:0]        wgt_q, wgt_d;
  logic signed [15:0] cpl_q, cpl_d, prev_q, prev_d;
  logic signed [14:0] shift_q, shift_d;
  logic [CNT_W-1:0]   tick_q, tick_d;

  // latched event
  logic signed [15:0] x_q, x_d, m_q, m_d;
  logic [DT_W-1:0]    dt_q, dt_d;
  logic signed [13:0] r_q, r_d, sl_q, sl_d;
  logic signed [14:0] ks_q, ks_d;

  // work registers
  logic signed [PROD_W-1:0] p_q, p_d;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [16:0]              pd_q, pd_d, td_q, td_d;
  logic signed [19:0]       drv_q, drv_d;
  logic signed [25:0]       lrr_q, lrr_d;
  logic [19:0]              earg_q, earg_d;
  logic [16:0]              eacc_q, eacc_d;
  logic [4:0]               ek_q, ek_d;
  logic                     zneg_q, zneg_d;
  logic [28:0]              rem_q, rem_d;
  logic [29:0]              dsh_q, dsh_d;
  logic [12:0]              quo_q, quo_d;
  logic [3:0]               dcnt_q, dcnt_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic signed [ACT_W-1:0]  out_act_q, out_act_d;
  logic [CNT_W-1:0]         out_cnt_q, out_cnt_d;

  // clamped configuration
  logic [18:0]        prate_c, trate_c;
  logic signed [15:0] thr_c;
  logic [16:0]        gain_c;
  logic [12:0]        lr_c;
  logic [15:0]        wfl_c, wcl_c, homeo_c;

  // clamped event fields
  logic signed [15:0] x_in, m_in;
  logic [DT_W-1:0]    dt_in;
  logic signed [13:0] r_in, sl_in;
  logic signed [14:0] ks_in;

  // exp argument forming, shared result helpers
  logic [40:0]        dec_sum;
  logic               dec_zero;
  logic [PROD_W-1:0]  z_mag;
  logic [38:0]        th_sum;
  logic               th_zero;
  logic [17:0]        den_c;
  logic signed [13:0] absa_c;
  logic signed [17:0] hsum, wsum, csum;
  logic               ek_last;

  assign prate_c = (pdr_q > 19'd409600) ? 19'd409600 : pdr_q;
  assign trate_c = (tdr_q > 19'd409600) ? 19'd409600 : tdr_q;
  assign thr_c   = (thr_q > 16'sd16384) ? 16'sd16384 :
                   (thr_q < -16'sd16384) ? -16'sd16384 : thr_q;
  assign gain_c  = (gain_q > 17'd65536) ? 17'd65536 : gain_q;
  assign lr_c    = (lr_q > 13'd4096) ? 13'd4096 : lr_q;
  assign homeo_c = (homeo_q > 16'd40960) ? 16'd40960 : homeo_q;
  assign wfl_c   = (wfl_q < 16'd4) ? 16'd4 : (wfl_q > 16'd40960) ? 16'd40960 : wfl_q;
  assign wcl_c   = (wcl_q < wfl_c) ? wfl_c : (wcl_q > 16'd40960) ? 16'd40960 : wcl_q;

  assign x_in  = (in_i.stimulus > 16'sd16384) ? 16'sd16384 :
                 (in_i.stimulus < -16'sd16384) ? -16'sd16384 : in_i.stimulus;
  assign m_in  = (in_i.modulation_value > 16'sd16384) ? 16'sd16384 :
                 (in_i.modulation_value < -16'sd16384) ? -16'sd16384 :
                 in_i.modulation_value;
  assign dt_in = (in_i.time_step == '0) ? DT_W'(1) :
                 (in_i.time_step > 21'd1048576) ? 21'd1048576 : in_i.time_step;
  assign r_in  = (in_i.reward_value > 14'sd4096) ? 14'sd4096 :
                 (in_i.reward_value < -14'sd4096) ? -14'sd4096 : in_i.reward_value;
  assign sl_in = (in_i.source_level > 14'sd4096) ? 14'sd4096 :
                 (in_i.source_level < -14'sd4096) ? -14'sd4096 : in_i.source_level;
  assign ks_in = (in_i.coupling_strength > 15'sd8192) ? 15'sd8192 :
                 (in_i.coupling_strength < -15'sd8192) ? -15'sd8192 :
                 in_i.coupling_strength;

  // decay argument: rate*dt rounded to Q.16; 16.0 or more gives exp of zero
  assign dec_sum  = p_q[40:0] + 41'd32768;
  assign dec_zero = |dec_sum[40:36];
  // tanh argument: 2|z| in Q.16 from z in Q.24
  assign z_mag    = p_q[PROD_W-1] ? PROD_W'(-p_q) : PROD_W'(p_q);
  assign th_sum   = z_mag[38:0] + 39'd64;
  assign th_zero  = |th_sum[38:27];
  assign den_c    = 18'h10000 + 18'(eacc_q);
  assign absa_c   = act_q[13] ? -act_q : act_q;
  assign ek_last  = (ek_q == 5'(EXP_STEPS - 1));

  assign hsum = 18'(shift_q) + 18'(rnd_sh(p_q, 32));
  assign wsum = $signed({2'b00, wgt_q}) + 18'(rnd_sh(p_q, 36));
  assign csum = 18'(cpl_q) + 18'(rnd_sh(p_q, 12));

  assign p_d = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    pot_d   = pot_q;
    act_d   = act_q;
    trace_d = trace_q;
    wgt_d   = wgt_q;
    cpl_d   = cpl_q;
    prev_d  = prev_q;
    shift_d = shift_q;
    tick_d  = tick_q;
    x_d     = x_q;
    m_d     = m_q;
    dt_d    = dt_q;
    r_d     = r_q;
    sl_d    = sl_q;
    ks_d    = ks_q;
    pd_d    = pd_q;
    td_d    = td_q;
    drv_d   = drv_q;
    lrr_d   = lrr_q;
    earg_d  = earg_q;
    eacc_d  = eacc_q;
    ek_d    = ek_q;
    zneg_d  = zneg_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    mul_a   = '0;
    mul_b   = '0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_act_d   = out_act_q;
    out_cnt_d   = out_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d  = x_in;
          m_d  = m_in;
          dt_d = dt_in;
          r_d  = r_in;
          sl_d = sl_in;
          ks_d = ks_in;
          case (func_e'(in_i.func))
            FN_PULSE:  state_d = S_PD0;
            FN_REINF:  state_d = S_R0;
            FN_COUPLE: state_d = S_C0;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_PD0: begin
        mul_a   = MUL_W'($signed({1'b0, prate_c}));
        mul_b   = MUL_W'($signed({1'b0, dt_q}));
        state_d = S_PD1;
      end
      S_PD1: begin
        earg_d  = dec_zero ? '0 : dec_sum[35:16];
        eacc_d  = dec_zero ? '0 : 17'h10000;
        ek_d    = '0;
        ret_d   = S_TD0;
        state_d = S_EXPM;
      end
      S_TD0: begin
        pd_d    = eacc_q;
        mul_a   = MUL_W'($signed({1'b0, trate_c}));
        mul_b   = MUL_W'($signed({1'b0, dt_q}));
        state_d = S_TD1;
      end
      S_TD1: begin
        earg_d  = dec_zero ? '0 : dec_sum[35:16];
        eacc_d  = dec_zero ? '0 : 17'h10000;
        ek_d    = '0;
        ret_d   = S_XW;
        state_d = S_EXPM;
      end
      // walk the argument bits; a clear bit is skipped without a multiply
      S_EXPM: begin
        if (earg_q[ek_q]) begin
          mul_a   = MUL_W'($signed({1'b0, eacc_q}));
          mul_b   = MUL_W'($signed({1'b0, EXP_TAB[ek_q]}));
          state_d = S_EXPR;
        end else if (ek_last) begin
          state_d = ret_q;
        end else begin
          ek_d = ek_q + 5'd1;
        end
      end
      S_EXPR: begin
        eacc_d = 17'((p_q[32:0] + 33'd32768) >> 16);
        if (ek_last) begin
          state_d = ret_q;
        end else begin
          ek_d    = ek_q + 5'd1;
          state_d = S_EXPM;
        end
      end
      S_XW: begin
        td_d    = eacc_q;
        mul_a   = MUL_W'(x_q);
        mul_b   = MUL_W'($signed({1'b0, wgt_q}));
        state_d = S_MT;
      end
      S_MT: begin
        drv_d   = 20'(rnd_sh(p_q, 12)) + 20'(cpl_q);
        mul_a   = MUL_W'(m_q);
        mul_b   = MUL_W'(trace_q);
        state_d = S_DRV;
      end
      S_DRV: begin
        drv_d   = drv_q + 20'(rnd_sh(p_q, 12));
        state_d = S_PM;
      end
      S_PM: begin
        mul_a   = MUL_W'(pot_q) - MUL_W'(drv_q);
        mul_b   = MUL_W'($signed({1'b0, pd_q}));
        state_d = S_POT;
      end
      S_POT: begin
        pot_d   = drv_q + 20'(rnd_sh(p_q, 16));
        state_d = S_Z;
      end
      S_Z: begin
        mul_a   = MUL_W'($signed({1'b0, gain_c}));
        mul_b   = MUL_W'(pot_q) - MUL_W'(thr_c) - MUL_W'(shift_q);
        state_d = S_TA;
      end
      S_TA: begin
        zneg_d  = p_q[PROD_W-1];
        earg_d  = th_zero ? '0 : th_sum[26:7];
        eacc_d  = th_zero ? '0 : 17'h10000;
        ek_d    = '0;
        ret_d   = S_DV0;
        state_d = S_EXPM;
      end
      // tanh magnitude = round(4096*(1-e)/(1+e)) by restoring division
      S_DV0: begin
        rem_d   = 29'({17'h10000 - eacc_q, 12'd0}) + 29'(den_c >> 1);
        dsh_d   = {den_c, 12'd0};
        quo_d   = '0;
        dcnt_d  = 4'd12;
        state_d = S_DIV;
      end
      S_DIV: begin
        if ({1'b0, rem_q} >= dsh_q) begin
          rem_d = rem_q - dsh_q[28:0];
          quo_d = {quo_q[11:0], 1'b1};
        end else begin
          quo_d = {quo_q[11:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        if (dcnt_q == '0) begin
          state_d = S_ACT;
        end else begin
          dcnt_d = dcnt_q - 4'd1;
        end
      end
      S_ACT: begin
        act_d   = zneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
        state_d = S_TDM;
      end
      S_TDM: begin
        mul_a   = MUL_W'(trace_q) - MUL_W'(act_q);
        mul_b   = MUL_W'($signed({1'b0, td_q}));
        state_d = S_TR;
      end
      S_TR: begin
        trace_d = act_q + 14'(rnd_sh(p_q, 16));
        mul_a   = MUL_W'($signed({1'b0, homeo_c}));
        mul_b   = MUL_W'(absa_c) - MUL_W'(TARGET_ACT);
        state_d = S_H1;
      end
      S_H1: begin
        mul_a   = $signed(p_q[MUL_W-1:0]);
        mul_b   = MUL_W'($signed({1'b0, dt_q}));
        state_d = S_H2;
      end
      S_H2: begin
        if (hsum > 18'sd8192) begin
          shift_d = 15'sd8192;
        end else if (hsum < -18'sd8192) begin
          shift_d = -15'sd8192;
        end else begin
          shift_d = hsum[14:0];
        end
        cpl_d   = '0;
        prev_d  = x_q;
        tick_d  = tick_q + CNT_W'(1);
        state_d = S_OUT;
      end
      // hold until the output register is free
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_act_d   = act_q;
          out_cnt_d   = tick_q;
          state_d     = S_IDLE;
        end
      end
      S_R0: begin
        mul_a   = MUL_W'($signed({1'b0, lr_c}));
        mul_b   = MUL_W'(r_q);
        state_d = S_R1;
      end
      S_R1: begin
        lrr_d   = p_q[25:0];
        mul_a   = MUL_W'(trace_q);
        mul_b   = MUL_W'(prev_q);
        state_d = S_R2;
      end
      S_R2: begin
        mul_a   = MUL_W'(lrr_q);
        mul_b   = $signed(p_q[MUL_W-1:0]);
        state_d = S_R3;
      end
      S_R3: begin
        if (wsum < $signed({2'b00, wfl_c})) begin
          wgt_d = wfl_c;
        end else if (wsum > $signed({2'b00, wcl_c})) begin
          wgt_d = wcl_c;
        end else begin
          wgt_d = wsum[15:0];
        end
        state_d = S_IDLE;
      end
      S_C0: begin
        mul_a   = MUL_W'(sl_q);
        mul_b   = MUL_W'(ks_q);
        state_d = S_C1;
      end
      S_C1: begin
        if (csum > 18'sd16384) begin
          cpl_d = 16'sd16384;
        end else if (csum < -18'sd16384) begin
          cpl_d = -16'sd16384;
        end else begin
          cpl_d = csum[15:0];
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      pot_q       <= '0;
      act_q       <= '0;
      trace_q     <= '0;
      wgt_q       <= WGT_RESET;
      cpl_q       <= '0;
      prev_q      <= '0;
      shift_q     <= '0;
      tick_q      <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      pot_q       <= pot_d;
      act_q       <= act_d;
      trace_q     <= trace_d;
      wgt_q       <= wgt_d;
      cpl_q       <= cpl_d;
      prev_q      <= prev_d;
      shift_q     <= shift_d;
      tick_q      <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    m_q       <= m_d;
    dt_q      <= dt_d;
    r_q       <= r_d;
    sl_q      <= sl_d;
    ks_q      <= ks_d;
    p_q       <= p_d;
    pd_q      <= pd_d;
    td_q      <= td_d;
    drv_q     <= drv_d;
    lrr_q     <= lrr_d;
    earg_q    <= earg_d;
    eacc_q    <= eacc_d;
    ek_q      <= ek_d;
    zneg_q    <= zneg_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    quo_q     <= quo_d;
    dcnt_q    <= dcnt_d;
    out_act_q <= out_act_d;
    out_cnt_q <= out_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdr_q   <= 19'd8192;
      tdr_q   <= 19'd4096;
      thr_q   <= 16'sd614;
      gain_q  <= 17'd4096;
      lr_q    <= 13'd205;
      wfl_q   <= 16'd410;
      wcl_q   <= 16'd8192;
      homeo_q <= 16'd82;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PDECAY: pdr_q   <= cfg_data_i;
        REG_TDECAY: tdr_q   <= cfg_data_i;
        REG_THRESH: thr_q   <= $signed(cfg_data_i[15:0]);
        REG_GAIN:   gain_q  <= cfg_data_i[16:0];
        REG_LRATE:  lr_q    <= cfg_data_i[12:0];
        REG_WFLOOR: wfl_q   <= cfg_data_i[15:0];
        REG_WCEIL:  wcl_q   <= cfg_data_i[15:0];
        REG_HOMEO:  homeo_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.activation_out = out_act_q;
  assign out_o.pulse_count    = out_cnt_q;

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || out_o.ready)) |=> out_o.valid)
    else $error("pulse result not loaded into output register");

  a_wgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R3) |=> (wgt_q >= wfl_c && wgt_q <= wcl_c))
    else $error("weight outside its limits after reinforce");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACT) |-> (quo_q <= 13'd4096))
    else $error("tanh quotient above 1.0");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift_q >= -15'sd8192 && shift_q <= 15'sd8192))
    else $error("threshold shift out of range");

endmodule

`default_nettype wire

[tb/tb_adaptive_leaky_synapse.sv]
// ----------------------------------------------------------------------------
// Adaptive leaky synapse testbench
// Drives pulse, reinforce and couple events with random gaps and output
// stalls. A built-in fixed-point predictor tracks the synapse state and
// configuration. Each activation word is checked against the predicted
// activation and pulse count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adaptive_leaky_synapse;
  import als_pkg::*;

  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  DRAIN_WAIT  = 200;
  localparam int  REG_COUNT   = 8;
  localparam longint WEIGHT_ONE = 4096;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [STIM_W-1:0] stim;
    logic signed [STIM_W-1:0] modv;
    logic [DT_W-1:0]          dt;
    logic signed [REW_W-1:0]  reward;
    logic signed [SRC_W-1:0]  src;
    logic signed [CPL_W-1:0]  strength;
  } event_t;

  typedef struct packed {
    logic signed [ACT_W-1:0] act;
    logic [CNT_W-1:0]        count;
  } activation_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  als_in_if  ev_if ();
  als_out_if act_if ();

  adaptive_leaky_synapse dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (ev_if),
    .out_o      (act_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state
  longint cfg_regs [REG_COUNT];
  longint potential, activation, trace, weight, coupling, last_stim, thr_shift;
  logic [CNT_W-1:0] tick_count;

  activation_t expected_words [$];
  int  error_count;
  int  cycle_count;
  bit  quiet_mode;
  int  hold_off_cycles;

  const int reg_bits [REG_COUNT] = '{19, 19, 16, 17, 13, 16, 16, 16};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (longint'(1) <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint exp_neg_q16(longint a);
    longint acc;
    acc = 65536;
    if (a >= (longint'(16) <<< 16)) return 0;
    for (int k = 0; k < EXP_STEPS; k++)
      if (a[k]) acc = (acc * longint'(EXP_TAB[k]) + 32768) >>> 16;
    return acc;
  endfunction

  function automatic longint floor_w();
    return clampl(cfg_regs[REG_WFLOOR], 4, 40960);
  endfunction

  function automatic longint ceil_w();
    return clampl(cfg_regs[REG_WCEIL], floor_w(), 40960);
  endfunction

  function automatic void reset_model();
    cfg_regs = '{8192, 4096, 614, 4096, 205, 410, 8192, 82};
    potential = 0; activation = 0; trace = 0; coupling = 0;
    last_stim = 0; thr_shift = 0; tick_count = '0;
    weight = clampl(WEIGHT_ONE, floor_w(), ceil_w());
  endfunction

  // Advance the synapse state by one event; push a word for a pulse.
  function automatic void predict_event(event_t ev);
    longint dt, x, m, pd, td, drive, z, mag, e, t, a, absa, r, lr, s, k;
    case (func_e'(ev.func))
      FN_PULSE: begin
        dt = clampl(longint'(ev.dt), 1, 1048576);
        x  = clampl(longint'(ev.stim), -16384, 16384);
        m  = clampl(longint'(ev.modv), -16384, 16384);
        pd = exp_neg_q16((clampl(cfg_regs[REG_PDECAY], 0, 409600) * dt + 32768) >>> 16);
        td = exp_neg_q16((clampl(cfg_regs[REG_TDECAY], 0, 409600) * dt + 32768) >>> 16);
        drive = round_shift(x * weight, 12) + coupling + round_shift(m * trace, 12);
        potential = drive + round_shift((potential - drive) * pd, 16);
        z = clampl(cfg_regs[REG_GAIN], 0, 65536) * (potential
            - clampl(longint'($signed(cfg_regs[REG_THRESH][15:0])), -16384, 16384)
            - thr_shift);
        mag = z < 0 ? -z : z;
        e = exp_neg_q16((mag + 64) >>> 7);
        t = (4096 * (65536 - e) + ((65536 + e) >>> 1)) / (65536 + e);
        a = z < 0 ? -t : t;
        activation = a;
        trace = a + round_shift((trace - a) * td, 16);
        absa = a < 0 ? -a : a;
        thr_shift = clampl(thr_shift + round_shift(clampl(cfg_regs[REG_HOMEO], 0, 40960)
                    * (absa - 1434) * dt, 32), -8192, 8192);
        coupling = 0;
        last_stim = x;
        tick_count = tick_count + 1'b1;
        expected_words.push_back('{act: a[ACT_W-1:0], count: tick_count});
      end
      FN_REINF: begin
        r  = clampl(longint'(ev.reward), -4096, 4096);
        lr = clampl(cfg_regs[REG_LRATE], 0, 4096);
        weight = clampl(weight + round_shift(lr * r * trace * last_stim, 36),
                        floor_w(), ceil_w());
      end
      FN_COUPLE: begin
        s = clampl(longint'(ev.src), -4096, 4096);
        k = clampl(longint'(ev.strength), -8192, 8192);
        coupling = clampl(coupling + round_shift(s * k, 12), -16384, 16384);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: random stalls plus an occasional long hold-off.
  initial begin
    int low_left;
    low_left = 0;
    act_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        act_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (low_left > 0) begin
        act_if.ready <= 1'b0;
        low_left--;
      end else begin
        act_if.ready <= 1'b1;
        low_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    activation_t exp_w;
    if (rst_ni && act_if.valid && act_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: activation_out %0d pulse_count %0d",
               act_if.activation_out, act_if.pulse_count);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (act_if.activation_out !== exp_w.act) begin
          $error("activation_out expected %0d actual %0d", exp_w.act,
                 act_if.activation_out);
          error_count++;
        end
        if (act_if.pulse_count !== exp_w.count) begin
          $error("pulse_count expected %0d actual %0d", exp_w.count,
                 act_if.pulse_count);
          error_count++;
        end
      end
    end
  end

  task automatic send_event(event_t ev);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      ev_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    ev_if.valid             <= 1'b1;
    ev_if.func              <= ev.func;
    ev_if.stimulus          <= ev.stim;
    ev_if.modulation_value  <= ev.modv;
    ev_if.time_step         <= ev.dt;
    ev_if.reward_value      <= ev.reward;
    ev_if.source_level      <= ev.src;
    ev_if.coupling_strength <= ev.strength;
    do @(posedge clk_i); while (!ev_if.ready);
    predict_event(ev);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    ev_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cfg_regs[idx] = longint'(value) & ((longint'(1) <<< reg_bits[idx]) - 1);
  endtask

  function automatic event_t make_event(func_e f, int stim, int modv, int dt,
                                        int rew, int src, int str);
    event_t ev;
    ev.func = f; ev.stim = STIM_W'(stim); ev.modv = STIM_W'(modv);
    ev.dt = DT_W'(dt); ev.reward = REW_W'(rew); ev.src = SRC_W'(src);
    ev.strength = CPL_W'(str);
    return ev;
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    int r;
    ev = event_t'({$urandom, $urandom, $urandom, $urandom});
    r = $urandom_range(0, 99);
    ev.func = r < 50 ? FN_PULSE : r < 70 ? FN_REINF : r < 92 ? FN_COUPLE : FN_NONE;
    // Keep most stimuli and steps in range so the state stays lively.
    if ($urandom_range(0, 3) != 0) begin
      ev.stim = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      ev.modv = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      ev.reward = $signed(14'($urandom_range(0, 8192))) - 14'sd4096;
    end
    case ($urandom_range(0, 3))
      0: ev.dt = DT_W'($urandom_range(1, 2000));
      1: ev.dt = DT_W'($urandom_range(1, 65536));
      2: ev.dt = DT_W'($urandom_range(0, 1048576));
      default: ;
    endcase
    return ev;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_event(rand_event());
  endtask

  task automatic test_directed();
    send_event(make_event(FN_PULSE, 16384, 16384, 1048576, 0, 0, 0));
    send_event(make_event(FN_REINF, 0, 0, 0, 4096, 0, 0));
    send_event(make_event(FN_PULSE, -16384, -16384, 1, 0, 0, 0));
    send_event(make_event(FN_PULSE, 32767, -32768, 0, 0, 0, 0));
    send_event(make_event(FN_PULSE, -32768, 32767, 2097151, 0, 0, 0));
    send_event(make_event(FN_REINF, 0, 0, 0, -4096, 0, 0));
    send_event(make_event(FN_REINF, 0, 0, 0, 8191, 0, 0));
    send_event(make_event(FN_REINF, 0, 0, 0, -8192, 0, 0));
    send_event(make_event(FN_COUPLE, 0, 0, 0, 0, 4096, 8192));
    send_event(make_event(FN_COUPLE, 0, 0, 0, 0, 8191, 16383));
    send_event(make_event(FN_COUPLE, 0, 0, 0, 0, 4096, 8192));
    send_event(make_event(FN_PULSE, 0, 0, 4096, 0, 0, 0));
    send_event(make_event(FN_COUPLE, 0, 0, 0, 0, -8192, 16383));
    send_event(make_event(FN_COUPLE, 0, 0, 0, 0, -4096, -8192));
    send_event(make_event(FN_PULSE, 100, 0, 100, 0, 0, 0));
    send_event(make_event(FN_NONE, 1234, 5, 77, 3, 4, 5));
    send_event(make_event(FN_PULSE, 4096, 4096, 1000, 0, 0, 0));
    send_event(make_event(FN_REINF, 0, 0, 0, 4096, 0, 0));
    send_event(make_event(FN_PULSE, 0, 0, 1048577, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_config_settings();
    write_reg(REG_PDECAY, '0); write_reg(REG_TDECAY, '0);
    write_reg(REG_THRESH, 19'h08000); write_reg(REG_GAIN, '0);
    write_reg(REG_LRATE, '0); write_reg(REG_WFLOOR, '0);
    write_reg(REG_WCEIL, '0); write_reg(REG_HOMEO, '0);
    run_random(60);
    wait_idle();
    for (int i = 0; i < REG_COUNT; i++) write_reg(cfg_idx_e'(i), '1);
    run_random(60);
    wait_idle();
    write_reg(REG_PDECAY, 409600); write_reg(REG_TDECAY, 409600);
    write_reg(REG_THRESH, 19'h0C000); write_reg(REG_GAIN, 65536);
    write_reg(REG_LRATE, 4096); write_reg(REG_WFLOOR, 4);
    write_reg(REG_WCEIL, 40960); write_reg(REG_HOMEO, 40960);
    run_random(60);
    wait_idle();
    write_reg(REG_THRESH, 16384); write_reg(REG_WFLOOR, 20000);
    write_reg(REG_WCEIL, 100);
    run_random(40);
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < REG_COUNT; i++) write_reg(cfg_idx_e'(i), $urandom);
      run_random(40);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 3000;
    quiet_mode = 1'b1;
    for (int i = 0; i < 12; i++)
      send_event(make_event(FN_PULSE, $urandom_range(0, 16384), 0, 500, 0, 0, 0));
    quiet_mode = 1'b0;
    wait_idle();
  endtask

  task automatic test_random();
    write_reg(REG_PDECAY, 8192); write_reg(REG_TDECAY, 4096);
    write_reg(REG_THRESH, 614); write_reg(REG_GAIN, 4096);
    write_reg(REG_LRATE, 2048); write_reg(REG_WFLOOR, 410);
    write_reg(REG_WCEIL, 16384); write_reg(REG_HOMEO, 82);
    run_random(195);
    quiet_mode = 1'b1;
    run_random(100);
    quiet_mode = 1'b0;
    run_random(195);
    wait_idle();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    quiet_mode = 1'b0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    ev_if.valid = 1'b0; ev_if.func = '0; ev_if.stimulus = '0;
    ev_if.modulation_value = '0; ev_if.time_step = '0; ev_if.reward_value = '0;
    ev_if.source_level = '0; ev_if.coupling_strength = '0;
    reset_model();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_settings();
    test_backpressure();
    test_random();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hdl/als_pkg.sv
hdl/als_if.sv
hdl/adaptive_leaky_synapse.sv
tb/tb_adaptive_leaky_synapse.sv
